@@ design/dcd_pkg.sv @@
// ----------------------------------------------------------------------------
// dcd_pkg: shared constants and types of the double clap direction detector
// Sample and register widths, stream packing, margins and heading codes.
// ----------------------------------------------------------------------------
package dcd_pkg;

   // Width of one microphone sample.
   localparam int SAMPLE_BITS = 10;

   // Register widths.
   localparam int TRIG_BITS  = 10;
   localparam int COUNT_BITS = 11;
   localparam int CSR_BITS   = 11;
   localparam int CSR_INDEX_BITS = 1;

   // Comparison width for a sample against the trigger level.
   localparam int CMP_BITS = (SAMPLE_BITS > TRIG_BITS) ? SAMPLE_BITS : TRIG_BITS;

   // Result fields.
   localparam int HEAD_BITS = 9;

   // Stream packing, padded to whole bytes.
   localparam int REQ_FIELD_BITS = 3 * SAMPLE_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 1 + HEAD_BITS + 1;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRIGGER_LEVEL = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLAP_WINDOW   = 1'd1;

   // Register reset values.
   localparam logic [TRIG_BITS-1:0]  TRIGGER_RESET = 10'd512;
   localparam logic [COUNT_BITS-1:0] WINDOW_RESET  = 11'd1000;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX     = {COUNT_BITS{1'b1}};

   // Classification margins.
   localparam int SIMILAR_MARGIN = 30;
   localparam int LEVEL_MARGIN   = 15;

   // Heading codes in degrees.
   localparam logic signed [HEAD_BITS-1:0] HEAD_0    = 9'sd0;
   localparam logic signed [HEAD_BITS-1:0] HEAD_P60  = 9'sd60;
   localparam logic signed [HEAD_BITS-1:0] HEAD_M60  = -9'sd60;
   localparam logic signed [HEAD_BITS-1:0] HEAD_P120 = 9'sd120;
   localparam logic signed [HEAD_BITS-1:0] HEAD_M120 = -9'sd120;
   localparam logic signed [HEAD_BITS-1:0] HEAD_180  = 9'sd180;

   typedef struct packed {
      logic                        known;
      logic signed [HEAD_BITS-1:0] degrees;
   } heading_type;

endpackage

@@ design/dcd_classify.sv @@
// ----------------------------------------------------------------------------
// dcd_classify: direction sector classifier
// Compares each microphone pair for similarity and the third level against
// the pair average, giving one of six 60-degree sectors or no match.
// ----------------------------------------------------------------------------
module dcd_classify (
   input  logic [dcd_pkg::SAMPLE_BITS-1:0] level_fl,
   input  logic [dcd_pkg::SAMPLE_BITS-1:0] level_fr,
   input  logic [dcd_pkg::SAMPLE_BITS-1:0] level_bk,
   output dcd_pkg::heading_type            heading
);
   import dcd_pkg::*;

   localparam int W = SAMPLE_BITS + 2;

   typedef struct packed {
      logic higher;
      logic lower;
   } pair_result_type;

   function automatic pair_result_type pair_test(input logic [SAMPLE_BITS-1:0] p,
                                                 input logic [SAMPLE_BITS-1:0] q,
                                                 input logic [SAMPLE_BITS-1:0] t);
      logic [W-1:0]    pe, qe, te, avg, diff;
      pair_result_type r;
      pe   = W'(p);
      qe   = W'(q);
      te   = W'(t);
      avg  = (pe + qe) >> 1;
      diff = (pe > qe) ? (pe - qe) : (qe - pe);
      r.higher = 1'b0;
      r.lower  = 1'b0;
      if (diff < W'(SIMILAR_MARGIN)) begin
         r.higher = te > (avg + W'(LEVEL_MARGIN));
         r.lower  = (te + W'(LEVEL_MARGIN)) < avg;
      end
      return r;
   endfunction

   pair_result_type test_fl, test_fr, test_bk;

   assign test_fl = pair_test(level_fr, level_bk, level_fl);
   assign test_fr = pair_test(level_fl, level_bk, level_fr);
   assign test_bk = pair_test(level_fl, level_fr, level_bk);

   // Rules are tried in order; the first pair that gives a verdict wins.
   always_comb begin
      heading.known   = 1'b1;
      heading.degrees = HEAD_0;
      if (test_fl.higher) begin
         heading.degrees = HEAD_M60;
      end else if (test_fl.lower) begin
         heading.degrees = HEAD_P120;
      end else if (test_fr.higher) begin
         heading.degrees = HEAD_P60;
      end else if (test_fr.lower) begin
         heading.degrees = HEAD_M120;
      end else if (test_bk.higher) begin
         heading.degrees = HEAD_180;
      end else if (test_bk.lower) begin
         heading.degrees = HEAD_0;
      end else begin
         heading.known   = 1'b0;
         heading.degrees = HEAD_0;
      end
   end

endmodule

@@ design/double_clap_direction_detector.sv @@
// ----------------------------------------------------------------------------
// double_clap_direction_detector: double clap detection with direction
// Each request carries one tick of three microphone levels; each response
// reports whether the tick completed a double clap and the last heading.
//
// Usage:
//   - req_* takes one tick per request; rsp_* returns exactly one response
//     per request, in order.
//   - The request lands in an input register, the clap logic and the sector
//     classifier run in one pass, and the response register presents the
//     result.
//   - Throughput is one request per cycle, limited only by the response
//     register being drained.
//   - When rsp_tready is low, the response holds and the input register still
//     takes one more request; req_tready falls once both are full.
//   - Reset clears the pipeline, disarms the detector, zeroes the tick
//     counter and heading, and loads trigger level 512 and window 1000.
//   - csr_we writes trigger level (index 0) or clap window (index 1); write
//     only while no request is in flight.
// ----------------------------------------------------------------------------
module double_clap_direction_detector (
   input  logic                                 clock,
   input  logic                                 reset,
   // level_front_left, level_front_right, level_back
   input  logic [dcd_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // clap_fired, heading_degrees, heading_known
   output logic [dcd_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_we,
   input  logic [dcd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [dcd_pkg::CSR_BITS-1:0]         csr_wdata
);
   import dcd_pkg::*;

   // Configuration registers.
   logic [TRIG_BITS-1:0]  trigger_ff, trigger_in;
   logic [COUNT_BITS-1:0] window_ff, window_in;

   // Input register.
   logic                   in_valid_ff, in_valid_in;
   logic [SAMPLE_BITS-1:0] fl_ff, fr_ff, bk_ff;

   // Detector state.
   logic                  armed_ff, armed_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   heading_type           last_ff, last_in;

   // Response register.
   logic              out_valid_ff, out_valid_in;
   logic              out_fired_ff;
   heading_type       out_head_ff;

   logic        out_load;
   logic        advance;
   logic        clap;
   logic        fire;
   heading_type classified;

   assign out_load   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_load;
   assign req_tready = !in_valid_ff || out_load;

   always_comb begin
      trigger_in = trigger_ff;
      window_in  = window_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TRIGGER_LEVEL: trigger_in = csr_wdata[TRIG_BITS-1:0];
            CSR_CLAP_WINDOW:   window_in  = csr_wdata[COUNT_BITS-1:0];
            default:           ;
         endcase
      end
   end

   dcd_classify u_classify (
      .level_fl (fl_ff),
      .level_fr (fr_ff),
      .level_bk (bk_ff),
      .heading  (classified)
   );

   assign clap = (CMP_BITS'(fl_ff) > CMP_BITS'(trigger_ff)) ||
                 (CMP_BITS'(fr_ff) > CMP_BITS'(trigger_ff)) ||
                 (CMP_BITS'(bk_ff) > CMP_BITS'(trigger_ff));

   assign fire = clap && armed_ff && (count_ff < window_ff);

   always_comb begin
      armed_in = armed_ff;
      count_in = count_ff;
      last_in  = last_ff;
      if (advance) begin
         if (clap && (!armed_ff || count_ff > window_ff)) begin
            // First clap, or a stale one: arm and restart the count at one.
            armed_in = 1'b1;
            count_in = COUNT_BITS'(1);
         end else if (fire) begin
            armed_in = 1'b0;
            count_in = '0;
            last_in  = classified;
         end else begin
            // A clap exactly at the window disarms; the count still runs on.
            if (clap) begin
               armed_in = 1'b0;
            end
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + COUNT_BITS'(1);
            end
         end
      end
   end

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ff   <= TRIGGER_RESET;
         window_ff    <= WINDOW_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         armed_ff     <= 1'b0;
         count_ff     <= '0;
         last_ff      <= '0;
      end else begin
         trigger_ff   <= trigger_in;
         window_ff    <= window_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         armed_ff     <= armed_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         fl_ff <= req_tdata[SAMPLE_BITS-1:0];
         fr_ff <= req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
         bk_ff <= req_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
      end
      if (advance) begin
         out_fired_ff <= fire;
         out_head_ff  <= last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - RSP_FIELD_BITS){1'b0}},
                        out_head_ff.known, out_head_ff.degrees, out_fired_ff};

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the double clap direction detector
// Drives microphone ticks through the request stream, predicts every response
// from a local copy of the clap state machine and sector classifier, and
// compares each response field by field. A short directed table comes first,
// then random clap pairs, noise and quiet gaps under several register
// settings, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_top;
   import dcd_pkg::*;

   localparam int NUM_PHASES   = 9;
   localparam int PHASE_ITEMS  = 130;
   localparam int NO_SETTING   = -1;
   // A negative entry means the value is drawn at random for that phase.
   localparam int PHASE_TRIGGER [NUM_PHASES] = '{512, 0, 1023, 300, NO_SETTING, 700, 50,
                                                 NO_SETTING, 900};
   localparam int PHASE_WINDOW  [NUM_PHASES] = '{1000, 1, 2047, 6, NO_SETTING, 0, 2047,
                                                 NO_SETTING, 3};

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] back;
      logic [SAMPLE_BITS-1:0] right;
      logic [SAMPLE_BITS-1:0] left;
   } levels_type;

   typedef struct packed {
      logic                        fired;
      logic signed [HEAD_BITS-1:0] degrees;
      logic                        known;
   } detection_type;

   typedef enum logic {ROW_TICK, ROW_CSR} row_op_type;

   typedef struct {
      row_op_type op;
      int         a;
      int         b;
      int         c;
      bit         typed;
      bit         fired;
      int         heading;
      bit         known;
   } row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic [REQ_DATA_BITS-1:0]  req_tdata = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_BITS-1:0]       csr_wdata = '0;

   // Local copy of the detector state and registers.
   logic                        det_armed;
   logic [COUNT_BITS-1:0]       det_count;
   logic signed [HEAD_BITS-1:0] det_heading;
   logic                        det_known;
   logic [TRIG_BITS-1:0]        cfg_trigger;
   logic [COUNT_BITS-1:0]       cfg_window;

   detection_type pending_detections [$];
   row_type       plan [30];
   bit            no_idle = 1'b0;
   int            ready_stall = 0;
   int            mismatch_count = 0;
   int            request_count = 0;
   int            response_count = 0;
   int            fire_count = 0;
   int            known_count = 0;
   int            setting_count = 0;

   double_clap_direction_detector uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Returns 1 when t stands above the average of a similar pair, -1 when it
   // stands below, 0 when the pair differs too much or t is inside the margin.
   function automatic int pair_side(input int p, input int q, input int t);
      int avg;
      avg = (p + q) / 2;
      if ((p > q ? p - q : q - p) >= SIMILAR_MARGIN) return 0;
      if (t - LEVEL_MARGIN > avg) return 1;
      if (t + LEVEL_MARGIN < avg) return -1;
      return 0;
   endfunction

   function automatic detection_type predict_tick(input levels_type lv);
      int fl, fr, bk, side;
      logic fired;
      fl = lv.left;
      fr = lv.right;
      bk = lv.back;
      fired = 1'b0;
      if (lv.left > cfg_trigger || lv.right > cfg_trigger || lv.back > cfg_trigger) begin
         if (!det_armed || det_count > cfg_window) begin
            det_armed = 1'b1;
            det_count = '0;
         end else if (det_count < cfg_window) begin
            det_armed = 1'b0;
            det_count = '0;
            fired = 1'b1;
         end else begin
            det_armed = 1'b0;
         end
      end
      if (fired) begin
         side = pair_side(fr, bk, fl);
         if (side != 0) begin
            det_heading = side > 0 ? HEAD_M60 : HEAD_P120;
         end else begin
            side = pair_side(fl, bk, fr);
            if (side != 0) begin
               det_heading = side > 0 ? HEAD_P60 : HEAD_M120;
            end else begin
               side = pair_side(fl, fr, bk);
               det_heading = side > 0 ? HEAD_180 : HEAD_0;
            end
         end
         det_known = (side != 0);
      end else if (det_count != COUNT_MAX) begin
         det_count = det_count + 1'b1;
      end
      return '{fired: fired, degrees: det_heading, known: det_known};
   endfunction

   // A tick with every level at or below the trigger level.
   function automatic levels_type make_quiet(input int trig);
      levels_type lv;
      lv.left  = SAMPLE_BITS'($urandom_range(0, trig));
      lv.right = SAMPLE_BITS'($urandom_range(0, trig));
      lv.back  = SAMPLE_BITS'($urandom_range(0, trig));
      return lv;
   endfunction

   // A loud tick shaped for the classifier: a near-equal pair whose larger level lies above
   // the trigger level (when the trigger is below 1023) and a third microphone around their average.
   function automatic levels_type make_clap(input int trig);
      levels_type lv;
      int base, other, third, p, q;
      base  = $urandom_range(trig < 1023 ? trig + 1 : 1023, 1023);
      other = base - $urandom_range(0, SIMILAR_MARGIN + 5);
      if (other < 0) other = 0;
      third = (base + other) / 2 + $urandom_range(0, 120) - 60;
      if (third < 0) third = 0;
      if (third > 1023) third = 1023;
      if ($urandom_range(0, 1)) begin
         p = base;
         q = other;
      end else begin
         p = other;
         q = base;
      end
      case ($urandom_range(0, 2))
         0: lv = '{back: SAMPLE_BITS'(q), right: SAMPLE_BITS'(p),
                   left: SAMPLE_BITS'(third)};
         1: lv = '{back: SAMPLE_BITS'(q), right: SAMPLE_BITS'(third),
                   left: SAMPLE_BITS'(p)};
         default: lv = '{back: SAMPLE_BITS'(third), right: SAMPLE_BITS'(q),
                         left: SAMPLE_BITS'(p)};
      endcase
      return lv;
   endfunction

   task automatic send_tick(input levels_type lv, input bit typed,
                            input detection_type typed_want);
      detection_type want;
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {{(REQ_DATA_BITS - REQ_FIELD_BITS){1'b0}}, lv};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      want = predict_tick(lv);
      pending_detections.push_back(typed ? typed_want : want);
      request_count++;
   endtask

   // Registers change only with the pipeline drained.
   task automatic write_csr(input int index, input int value);
      req_tvalid <= 1'b0;
      while (pending_detections.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index[CSR_INDEX_BITS-1:0];
      csr_wdata <= value[CSR_BITS-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == int'(CSR_TRIGGER_LEVEL)) cfg_trigger = value[TRIG_BITS-1:0];
      else cfg_window = value[COUNT_BITS-1:0];
      setting_count++;
   endtask

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("MISMATCH response %0d %s: got %0d, expected %0d",
               response_count, field, got, want);
      mismatch_count++;
   endtask

   // Response side: check every accepted response, then stall at random.
   always @(posedge clock) begin
      detection_type want;
      detection_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.fired   = rsp_tdata[0];
            got.degrees = rsp_tdata[HEAD_BITS:1];
            got.known   = rsp_tdata[HEAD_BITS+1];
            if (pending_detections.size() == 0) begin
               $display("MISMATCH response %0d arrived with no request pending",
                        response_count);
               mismatch_count++;
            end else begin
               want = pending_detections.pop_front();
               if (got.fired !== want.fired)
                  report_mismatch("clap_fired", got.fired, want.fired);
               if (got.degrees !== want.degrees)
                  report_mismatch("heading_degrees", got.degrees, want.degrees);
               if (got.known !== want.known)
                  report_mismatch("heading_known", got.known, want.known);
            end
            if (got.fired === 1'b1) fire_count++;
            if (got.fired === 1'b1 && got.known === 1'b1) known_count++;
            response_count++;
            ready_stall = no_idle ? 0 : $urandom_range(0, 11);
            if (ready_stall != 0) rsp_tready <= 1'b0;
         end else if (!rsp_tready) begin
            if (ready_stall > 0) ready_stall--;
            if (ready_stall == 0) rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      levels_type    lv;
      detection_type typed_want;
      int            trig, win, gap, sent;

      //      op        FL    FR    B     typed fired heading known
      plan = '{
         '{ROW_TICK,    0,    0,    0,    1, 0,    0, 0},
         '{ROW_TICK,  512,  512,  512,    1, 0,    0, 0},
         '{ROW_TICK, 1023,    0,    0,    1, 0,    0, 0},
         '{ROW_TICK,  600,  100,  100,    1, 1,  -60, 1},
         '{ROW_TICK, 1023, 1023,    0,    1, 0,  -60, 1},
         '{ROW_TICK,  100,  600,  100,    1, 1,   60, 1},
         '{ROW_TICK,    0,    0, 1023,    1, 0,   60, 1},
         '{ROW_TICK,  100,  100,  600,    1, 1,  180, 1},
         '{ROW_TICK, 1023,    0,    0,    1, 0,  180, 1},
         '{ROW_TICK,  520, 1000, 1000,    1, 1,  120, 1},
         '{ROW_TICK,    0, 1023,    0,    1, 0,  120, 1},
         '{ROW_TICK, 1000,  520, 1000,    1, 1, -120, 1},
         '{ROW_TICK,    0,    0, 1023,    1, 0, -120, 1},
         '{ROW_TICK, 1000, 1000,  520,    1, 1,    0, 1},
         '{ROW_TICK, 1023, 1023, 1023,    1, 0,    0, 1},
         '{ROW_TICK,  600,  800, 1000,    1, 1,    0, 0},
         '{ROW_TICK, 1023,    0,    0,    0, 0,    0, 0},
         '{ROW_TICK, 1023,  700,  729,    0, 0,    0, 0},
         '{ROW_TICK, 1023,    0,    0,    0, 0,    0, 0},
         '{ROW_TICK, 1023,  700,  730,    0, 0,    0, 0},
         '{ROW_CSR, int'(CSR_CLAP_WINDOW), 2, 0, 0, 0, 0, 0},
         '{ROW_CSR, int'(CSR_TRIGGER_LEVEL), 0, 0, 0, 0, 0, 0},
         '{ROW_TICK,    0,    0,    1,    0, 0,    0, 0},
         '{ROW_TICK,    0,    0,    0,    0, 0,    0, 0},
         '{ROW_TICK,    1,    0,    0,    0, 0,    0, 0},
         '{ROW_TICK,    0,    1,    0,    0, 0,    0, 0},
         '{ROW_TICK,    0,    0,    0,    0, 0,    0, 0},
         '{ROW_TICK,    0,    0,    0,    0, 0,    0, 0},
         '{ROW_TICK,    0,    0,    5,    0, 0,    0, 0},
         '{ROW_TICK,   40,   40,    0,    0, 0,    0, 0}
      };

      det_armed   = 1'b0;
      det_count   = '0;
      det_heading = HEAD_0;
      det_known   = 1'b0;
      cfg_trigger = TRIGGER_RESET;
      cfg_window  = WINDOW_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].op == ROW_CSR) begin
            write_csr(plan[i].a, plan[i].b);
         end else begin
            lv = '{back: SAMPLE_BITS'(plan[i].c), right: SAMPLE_BITS'(plan[i].b),
                   left: SAMPLE_BITS'(plan[i].a)};
            typed_want = '{fired: plan[i].fired, degrees: HEAD_BITS'(plan[i].heading),
                           known: plan[i].known};
            send_tick(lv, plan[i].typed, typed_want);
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         trig = PHASE_TRIGGER[ph] < 0 ? $urandom_range(0, 1023) : PHASE_TRIGGER[ph];
         win  = PHASE_WINDOW[ph] < 0 ? $urandom_range(1, 40) : PHASE_WINDOW[ph];
         write_csr(int'(CSR_TRIGGER_LEVEL), trig);
         write_csr(int'(CSR_CLAP_WINDOW), win);
         no_idle = (ph % 3 == 1);

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
               if (cfg_window > 64) begin
                  gap = $urandom_range(0, 20);
               end else begin
                  case ($urandom_range(0, 2))
                     0: gap = int'(cfg_window) - 2 + $urandom_range(0, 2);
                     1: gap = $urandom_range(0, int'(cfg_window) + 2);
                     default: gap = $urandom_range(0, 3);
                  endcase
                  if (gap < 0) gap = 0;
               end
               send_tick(make_clap(trig), 1'b0, '0);
               repeat (gap) send_tick(make_quiet(trig), 1'b0, '0);
               send_tick(make_clap(trig), 1'b0, '0);
               sent += gap + 2;
            end else begin
               lv = REQ_FIELD_BITS'($urandom);
               send_tick(lv, 1'b0, '0);
               sent++;
            end
         end
      end

      req_tvalid <= 1'b0;
      while (pending_detections.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Ran %0d requests under %0d register writes, window edges included.",
               request_count, setting_count);
      $display("Saw %0d double claps, %0d of them with a known heading.",
               fire_count, known_count);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/dcd_pkg.sv
design/dcd_classify.sv
design/double_clap_direction_detector.sv
sim/tb_top.sv
